FILE: src/sva_pkg.sv
package sva_pkg;

    // Sizes of the clip space and of the voice bank.
    localparam int CLIP_COUNT    = 16;
    localparam int CLIP_W        = 4;
    localparam int CLIP_IDX_W    = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
    localparam int NUM_VOICES    = 3;
    localparam int VOICE_IDX_W   = 2;
    localparam int STAMP_W       = 32;
    localparam int COUNT_W       = 10;
    localparam int COUNT_MODULUS = 1000;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_PLAY     = 2'd0;
    localparam logic [1:0] OP_IRQ      = 2'd1;
    localparam logic [1:0] OP_STOP_ALL = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] play_mask;
        logic [1:0]  irq_voice;
    } sva_in_t;

    typedef struct packed {
        logic         started;
        logic [1:0]   voice;
        logic [3:0]   clip_number;
        logic         stopped;
        logic         last;
        logic [9:0]   begun_count;
        logic [9:0]   retired_count;
        logic [2:0]   active_mask;
    } sva_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PLAY,
        ST_IRQ,
        ST_STOP_ALL,
        ST_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_PLAY,
        STEP_IRQ,
        STEP_HALT,
        STEP_EMPTY
    } step_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   load;
        step_kind_t             kind;
        logic                   last;
        logic [CLIP_IDX_W-1:0]  clip_idx;
        logic [VOICE_IDX_W-1:0] voice_idx;
    } sva_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       irq_zero;
        logic       pending_zero;
        logic       hit;
        logic       rest_zero;
        logic       out_free;
    } sva_status_t;

    // Increment a count that wraps at the modulus.
    function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] value);
        logic [COUNT_W-1:0] result;
        if (value == COUNT_W'(COUNT_MODULUS - 1))
        begin
            result = '0;
        end
        else
        begin
            result = value + COUNT_W'(1);
        end
        return result;
    endfunction

endpackage

FILE: src/sva_ctrl.sv
module sva_ctrl
    import sva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sva_status_t status,
    output sva_cmd_t    cmd
);

    state_t                 state_reg, state_next;
    logic [CLIP_IDX_W-1:0]  clip_idx_reg, clip_idx_next;
    logic [VOICE_IDX_W-1:0] voice_idx_reg, voice_idx_next;

    // State and sequencing counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clip_idx_reg  <= '0;
            voice_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clip_idx_reg  <= clip_idx_next;
            voice_idx_reg <= voice_idx_next;
        end
    end

    // Next state: play scans clips one per cycle unless a hit waits on the output register, stop-all walks the voices.
    always_comb
    begin
        state_next     = state_reg;
        clip_idx_next  = clip_idx_reg;
        voice_idx_next = voice_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                clip_idx_next  = '0;
                voice_idx_next = '0;
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_PLAY:     state_next = status.pending_zero ? ST_EMPTY : ST_PLAY;
                    OP_IRQ:      state_next = status.irq_zero ? ST_EMPTY : ST_IRQ;
                    OP_STOP_ALL: state_next = ST_STOP_ALL;
                    default:     state_next = ST_EMPTY;
                endcase
            end
            ST_PLAY:
            begin
                if (!status.hit)
                begin
                    clip_idx_next = clip_idx_reg + CLIP_IDX_W'(1);
                end
                else if (status.out_free)
                begin
                    if (status.rest_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        clip_idx_next = clip_idx_reg + CLIP_IDX_W'(1);
                    end
                end
            end
            ST_STOP_ALL:
            begin
                if (status.out_free)
                begin
                    if (voice_idx_reg == VOICE_IDX_W'(NUM_VOICES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        voice_idx_next = voice_idx_reg + VOICE_IDX_W'(1);
                    end
                end
            end
            ST_IRQ, ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: a step is issued only when the output register can take it.
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.load      = in_valid && (state_reg == ST_IDLE);
        cmd.kind      = STEP_NONE;
        cmd.last      = 1'b0;
        cmd.clip_idx  = clip_idx_reg;
        cmd.voice_idx = voice_idx_reg;
        case (state_reg)
            ST_PLAY:
            begin
                if (status.hit && status.out_free)
                begin
                    cmd.kind = STEP_PLAY;
                    cmd.last = status.rest_zero;
                end
            end
            ST_STOP_ALL:
            begin
                if (status.out_free)
                begin
                    cmd.kind = STEP_HALT;
                    cmd.last = (voice_idx_reg == VOICE_IDX_W'(NUM_VOICES - 1));
                end
            end
            ST_IRQ:
            begin
                if (status.out_free)
                begin
                    cmd.kind = STEP_IRQ;
                    cmd.last = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.kind = STEP_EMPTY;
                    cmd.last = 1'b1;
                end
            end
            default:
            begin
                cmd.kind = STEP_NONE;
            end
        endcase
    end

endmodule

FILE: src/sva_datapath.sv
module sva_datapath
    import sva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sva_in_t     in_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  sva_cmd_t    cmd,
    output sva_status_t status,
    output logic        out_valid,
    input  logic        out_ready,
    output sva_out_t    out_data
);

    // Configuration and the captured transaction.
    logic [15:0]           present_reg;
    logic [1:0]            op_reg;
    logic [1:0]            irq_reg;
    logic [CLIP_COUNT-1:0] pending_reg;

    // Voice bank and counters.
    logic [NUM_VOICES-1:0] busy_reg, busy_next;
    logic [NUM_VOICES-1:0] first_reg, first_next;
    logic [CLIP_W-1:0]     clip_reg [NUM_VOICES];
    logic [CLIP_W-1:0]     clip_next [NUM_VOICES];
    logic [STAMP_W-1:0]    stamp_reg [NUM_VOICES];
    logic [STAMP_W-1:0]    stamp_next [NUM_VOICES];
    logic [STAMP_W-1:0]    counter_reg, counter_next;
    logic [COUNT_W-1:0]    begun_reg, begun_next;
    logic [COUNT_W-1:0]    retired_reg, retired_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    sva_out_t              out_data_reg;
    sva_out_t              result;

    logic [CLIP_W-1:0]      cur_clip;
    logic [CLIP_COUNT-1:0]  cur_bit;
    logic                   match_found, free_found;
    logic [VOICE_IDX_W-1:0] match_idx, free_idx, old_idx, pick_idx, act_idx;
    logic                   was_busy;

    assign cur_clip = CLIP_W'(cmd.clip_idx);
    assign cur_bit  = CLIP_COUNT'(1) << cmd.clip_idx;

    // Status toward the controller.
    always_comb
    begin
        status.op           = op_reg;
        status.irq_zero     = (irq_reg == 2'd0);
        status.pending_zero = (pending_reg == '0);
        status.hit          = pending_reg[cmd.clip_idx];
        status.rest_zero    = ((pending_reg & ~cur_bit) == '0);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // Voice choice: same clip, else lowest free, else oldest stamp.
    always_comb
    begin
        match_found = 1'b0;
        match_idx   = '0;
        free_found  = 1'b0;
        free_idx    = '0;
        old_idx     = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (busy_reg[i] && (clip_reg[i] == cur_clip))
            begin
                match_found = 1'b1;
                match_idx   = VOICE_IDX_W'(i);
            end
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VOICE_IDX_W'(i);
            end
        end
        for (int i = 1; i < NUM_VOICES; i++)
        begin
            if (stamp_reg[i] < stamp_reg[old_idx])
            begin
                old_idx = VOICE_IDX_W'(i);
            end
        end
        if (match_found)
        begin
            pick_idx = match_idx;
        end
        else if (free_found)
        begin
            pick_idx = free_idx;
        end
        else
        begin
            pick_idx = old_idx;
        end
    end

    // Step action on the voice bank and the result it reports.
    always_comb
    begin
        busy_next    = busy_reg;
        first_next   = first_reg;
        clip_next    = clip_reg;
        stamp_next   = stamp_reg;
        counter_next = counter_reg;
        begun_next   = begun_reg;
        retired_next = retired_reg;
        act_idx      = '0;
        was_busy     = 1'b0;
        result       = '0;
        case (cmd.kind)
            STEP_PLAY:
            begin
                act_idx               = pick_idx;
                was_busy              = busy_reg[act_idx];
                counter_next          = counter_reg + STAMP_W'(1);
                begun_next            = count_inc(begun_reg);
                stamp_next[act_idx]   = counter_next;
                clip_next[act_idx]    = cur_clip;
                first_next[act_idx]   = 1'b1;
                busy_next[act_idx]    = 1'b1;
                result.started        = 1'b1;
                result.voice          = act_idx + 2'd1;
                result.clip_number    = cur_clip;
                result.stopped        = was_busy;
            end
            STEP_IRQ:
            begin
                act_idx      = irq_reg - 2'd1;
                result.voice = irq_reg;
                if (first_reg[act_idx])
                begin
                    first_next[act_idx] = 1'b0;
                end
                else
                begin
                    was_busy           = busy_reg[act_idx];
                    busy_next[act_idx] = 1'b0;
                    result.stopped     = was_busy;
                end
            end
            STEP_HALT:
            begin
                act_idx            = cmd.voice_idx;
                was_busy           = busy_reg[act_idx];
                busy_next[act_idx] = 1'b0;
                result.voice       = act_idx + 2'd1;
                result.stopped     = was_busy;
            end
            default:
            begin
                result = '0;
            end
        endcase
        if (was_busy)
        begin
            retired_next = count_inc(retired_reg);
        end
        result.last          = cmd.last;
        result.begun_count   = begun_next;
        result.retired_count = retired_next;
        result.active_mask   = busy_next;
    end

    // The output register fills on a step and drains on an output transaction.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.kind != STEP_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and voice bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= 16'hFFFF;
            busy_reg      <= '0;
            first_reg     <= '0;
            counter_reg   <= '0;
            begun_reg     <= '0;
            retired_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                clip_reg[i]  <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                present_reg <= cfg_data;
            end
            busy_reg      <= busy_next;
            first_reg     <= first_next;
            clip_reg      <= clip_next;
            stamp_reg     <= stamp_next;
            counter_reg   <= counter_next;
            begun_reg     <= begun_next;
            retired_reg   <= retired_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured transaction fields and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_data.operation;
            irq_reg     <= in_data.irq_voice;
            pending_reg <= in_data.play_mask[CLIP_COUNT-1:0] & present_reg[CLIP_COUNT-1:0];
        end
        else if (cmd.kind == STEP_PLAY)
        begin
            pending_reg <= pending_reg & ~cur_bit;
        end
        if (cmd.kind != STEP_NONE)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/sound_voice_allocator_core.sv
// Channel   Signals                        Direction  Content
// input     in_valid, in_ready, in_data    in         operation, play mask, irq voice
// output    out_valid, out_ready, out_data out        one result per started clip or action
// config    cfg_we, cfg_data               in         clip present mask
//
// One input transaction at a time: the sequencer accepts it, dispatches it, then
// scans the clip slots up to the last requested clip (at most 16 for a play
// request), walks the three voices for stop-all, or gives one result for an
// interrupt or an empty result. Reset clears all voices and counts and sets
// every clip present. A stalled output holds the sequencer.
module sound_voice_allocator_core
    import sva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sva_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output sva_out_t    out_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    sva_cmd_t    cmd;
    sva_status_t status;

    // Sequencer.
    sva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Voice bank, counters and output register.
    sva_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: verif/tb_sound_voice_allocator_core.sv
module tb_sound_voice_allocator_core;
    import sva_pkg::*;

    // Operation code that the block must answer with one empty result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to let pass once nothing is expected, and the watchdog bound.
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    sva_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    sva_out_t    out_data;
    logic        cfg_we;
    logic [15:0] cfg_data;

    // Shadow copy of the allocator state.
    logic [15:0]        present_mask;
    logic               v_busy  [NUM_VOICES];
    logic               v_first [NUM_VOICES];
    logic [CLIP_W-1:0]  v_clip  [NUM_VOICES];
    logic [STAMP_W-1:0] v_stamp [NUM_VOICES];
    logic [STAMP_W-1:0] stamp_now;
    logic [COUNT_W-1:0] begun_cnt;
    logic [COUNT_W-1:0] retired_cnt;
    bit                 begun_wrapped;
    bit                 retired_wrapped;

    // Results still owed by the block, oldest first.
    sva_out_t expected_results [$];

    int error_count;
    int quiet_cycles;
    int in_burst;
    int out_burst;
    int out_hold;

    sound_voice_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, period 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        else if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Counts wrap at the modulus; the flags note that a wrap has happened.
    function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] value,
                                                      ref bit wrapped);
        if (value == COUNT_W'(COUNT_MODULUS - 1))
        begin
            wrapped = 1'b1;
            return '0;
        end
        return value + COUNT_W'(1);
    endfunction

    task automatic clear_shadow();
        present_mask    = 16'hFFFF;
        stamp_now       = '0;
        begun_cnt       = '0;
        retired_cnt     = '0;
        begun_wrapped   = 1'b0;
        retired_wrapped = 1'b0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            v_busy[i]  = 1'b0;
            v_first[i] = 1'b0;
            v_clip[i]  = '0;
            v_stamp[i] = '0;
        end
    endtask

    // Stop one voice; tells whether it was busy.
    function automatic logic retire_voice(input int idx);
        logic was_busy;
        was_busy = v_busy[idx];
        if (was_busy)
        begin
            retired_cnt = bump_count(retired_cnt, retired_wrapped);
        end
        v_busy[idx] = 1'b0;
        return was_busy;
    endfunction

    // Voice for a clip: the one already playing it, a free one, else the oldest.
    function automatic int choose_voice(input logic [CLIP_W-1:0] clip);
        int best;
        best = -1;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            if (best < 0 && v_busy[i] && v_clip[i] == clip)
            begin
                best = i;
            end
        end
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            if (best < 0 && !v_busy[i])
            begin
                best = i;
            end
        end
        if (best < 0)
        begin
            best = 0;
            for (int i = 1; i < NUM_VOICES; i++)
            begin
                if (v_stamp[i] < v_stamp[best])
                begin
                    best = i;
                end
            end
        end
        return best;
    endfunction

    // One result, with the running counts and busy mask after its action.
    function automatic sva_out_t make_result(input logic started, input logic [1:0] voice,
                                             input logic [3:0] clip, input logic stopped);
        sva_out_t r;
        r               = '0;
        r.started       = started;
        r.voice         = voice;
        r.clip_number   = clip;
        r.stopped       = stopped;
        r.begun_count   = begun_cnt;
        r.retired_count = retired_cnt;
        r.active_mask   = {v_busy[2], v_busy[1], v_busy[0]};
        return r;
    endfunction

    // Work out every result of one accepted request and queue them.
    task automatic predict_allocation(input sva_in_t req);
        sva_out_t batch [16];
        int       n;
        int       idx;
        logic     st;
        n = 0;
        case (req.operation)
            OP_PLAY:
            begin
                for (int c = 0; c < CLIP_COUNT; c++)
                begin
                    if (req.play_mask[c] && present_mask[c])
                    begin
                        idx = choose_voice(CLIP_W'(c));
                        st = retire_voice(idx);
                        begun_cnt = bump_count(begun_cnt, begun_wrapped);
                        stamp_now = stamp_now + 1;
                        v_stamp[idx] = stamp_now;
                        v_clip[idx]  = CLIP_W'(c);
                        v_first[idx] = 1'b1;
                        v_busy[idx]  = 1'b1;
                        batch[n] = make_result(1'b1, 2'(idx + 1), 4'(c), st);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    batch[0] = make_result(1'b0, 2'd0, 4'd0, 1'b0);
                    n = 1;
                end
            end
            OP_IRQ:
            begin
                st = 1'b0;
                if (req.irq_voice != 2'd0)
                begin
                    idx = int'(req.irq_voice) - 1;
                    // The first interrupt only ends the first pass of the clip.
                    if (v_first[idx])
                    begin
                        v_first[idx] = 1'b0;
                    end
                    else
                    begin
                        st = retire_voice(idx);
                    end
                end
                batch[0] = make_result(1'b0, req.irq_voice, 4'd0, st);
                n = 1;
            end
            OP_STOP_ALL:
            begin
                for (int i = 0; i < NUM_VOICES; i++)
                begin
                    st = retire_voice(i);
                    batch[n] = make_result(1'b0, 2'(i + 1), 4'd0, st);
                    n++;
                end
            end
            default:
            begin
                batch[0] = make_result(1'b0, 2'd0, 4'd0, 1'b0);
                n = 1;
            end
        endcase
        batch[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            expected_results.push_back(batch[k]);
        end
    endtask

    function automatic sva_in_t make_request(input logic [1:0] op, input logic [15:0] mask,
                                             input logic [1:0] irqv);
        sva_in_t req;
        req.operation = op;
        req.play_mask = mask;
        req.irq_voice = irqv;
        return req;
    endfunction

    // Random request: mostly play requests of varied shape, then interrupts, stop-all and unused codes.
    function automatic sva_in_t random_request();
        sva_in_t req;
        int      roll;
        int      shape;
        req.play_mask = 16'($urandom);
        req.irq_voice = 2'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            req.operation = OP_PLAY;
            shape = $urandom_range(0, 99);
            if (shape < 40)
            begin
                req.play_mask = 16'($urandom);
            end
            else if (shape < 55)
            begin
                req.play_mask = 16'hFFFF;
            end
            else if (shape < 80)
            begin
                req.play_mask = 16'(1) << $urandom_range(0, 15);
            end
            else if (shape < 95)
            begin
                req.play_mask = (16'(1) << $urandom_range(0, 15))
                              | (16'(1) << $urandom_range(0, 15));
            end
            else
            begin
                req.play_mask = 16'h0000;
            end
        end
        else if (roll < 85)
        begin
            req.operation = OP_IRQ;
            if ($urandom_range(0, 9) != 0)
            begin
                req.irq_voice = 2'($urandom_range(1, 3));
            end
        end
        else if (roll < 95)
        begin
            req.operation = OP_STOP_ALL;
        end
        else
        begin
            req.operation = OP_UNUSED;
        end
        return req;
    endfunction

    // Offer one request and wait for its transaction, then predict it.
    task automatic send_request(input sva_in_t req);
        int gap;
        if (in_burst > 0)
        begin
            gap = 0;
            in_burst--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
            begin
                in_burst = $urandom_range(20, 60);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_allocation(req);
    endtask

    // Stop offering and wait until every owed result has come, then settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program the clip present mask; only called while the block is idle.
    task automatic write_presence(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        present_mask = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_play_requests();
        send_request(make_request(OP_PLAY, 16'h0000, 2'($urandom)));
        send_request(make_request(OP_PLAY, 16'h0001, 2'($urandom)));
        // Same clip again lands on the voice already playing it.
        send_request(make_request(OP_PLAY, 16'h0001, 2'($urandom)));
        send_request(make_request(OP_PLAY, 16'h0006, 2'($urandom)));
        // All voices busy: the oldest one is stolen.
        send_request(make_request(OP_PLAY, 16'h0008, 2'($urandom)));
        send_request(make_request(OP_PLAY, 16'hFFFF, 2'($urandom)));
        send_request(make_request(OP_PLAY, 16'h8000, 2'($urandom)));
    endtask

    task automatic test_voice_end();
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd0));
        // First interrupt clears the first pass, the second stops the voice.
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd1));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd1));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd1));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd2));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd3));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd3));
    endtask

    task automatic test_stop_all();
        send_request(make_request(OP_PLAY, 16'h0007, 2'($urandom)));
        send_request(make_request(OP_STOP_ALL, 16'($urandom), 2'($urandom)));
        send_request(make_request(OP_STOP_ALL, 16'($urandom), 2'($urandom)));
        // A voice stopped by stop-all still has its first pass to spend.
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd2));
        send_request(make_request(OP_IRQ, 16'($urandom), 2'd2));
    endtask

    task automatic test_unused_op();
        send_request(make_request(OP_UNUSED, 16'hFFFF, 2'd3));
        send_request(make_request(OP_UNUSED, 16'h0000, 2'd0));
    endtask

    task automatic test_present_mask();
        drain_results();
        write_presence(16'h0000);
        send_request(make_request(OP_PLAY, 16'hFFFF, 2'($urandom)));
        drain_results();
        write_presence(16'h8001);
        send_request(make_request(OP_PLAY, 16'hFFFF, 2'($urandom)));
        send_request(make_request(OP_PLAY, 16'h7FFE, 2'($urandom)));
        drain_results();
        write_presence(16'hFFFF);
    endtask

    // Mostly full-mask requests until both counts have wrapped past the modulus, at most 120 requests.
    task automatic test_count_wrap();
        int sent;
        sent = 0;
        in_burst = 30;
        while (!(begun_wrapped && retired_wrapped) && sent < 120)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(random_request());
            end
            else
            begin
                send_request(make_request(OP_PLAY, 16'hFFFF, 2'($urandom)));
            end
            sent++;
        end
    endtask

    task automatic run_random_phase(input logic [15:0] presence, input int count);
        drain_results();
        write_presence(presence);
        repeat (count) send_request(random_request());
    endtask

    task automatic test_random_traffic();
        run_random_phase(16'hFFFF, 80);
        run_random_phase(16'($urandom), 50);
        run_random_phase(16'h0000, 8);
        run_random_phase(16'h8001, 30);
        run_random_phase(16'($urandom), 40);
        run_random_phase(16'hFFFF, 30);
    endtask

    // Compare one field of a result.
    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check each result transaction against the oldest expectation.
    task automatic check_result(input sva_out_t got);
        sva_out_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            compare_field("started", 16'(want.started), 16'(got.started));
            compare_field("voice", 16'(want.voice), 16'(got.voice));
            compare_field("clip_number", 16'(want.clip_number), 16'(got.clip_number));
            compare_field("stopped", 16'(want.stopped), 16'(got.stopped));
            compare_field("last", 16'(want.last), 16'(got.last));
            compare_field("begun_count", 16'(want.begun_count), 16'(got.begun_count));
            compare_field("retired_count", 16'(want.retired_count), 16'(got.retired_count));
            compare_field("active_mask", 16'(want.active_mask), 16'(got.active_mask));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            check_result(out_data);
        end
    end

    // Result side back-pressure: random stalls with stretches of none.
    initial
    begin
        out_ready = 1'b0;
        out_burst = 0;
        out_hold  = 0;
        forever
        begin
            @(posedge clk);
            if (out_hold > 0)
            begin
                out_ready <= 1'b0;
                out_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_burst > 0)
                begin
                    out_burst--;
                end
                else if ($urandom_range(0, 99) < 3)
                begin
                    out_burst = $urandom_range(40, 160);
                end
                else if ($urandom_range(0, 99) < 30)
                begin
                    out_hold = pick_gap();
                end
            end
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        error_count  = 0;
        quiet_cycles = 0;
        in_burst     = 0;
        clear_shadow();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_play_requests();
        test_voice_end();
        test_stop_all();
        test_unused_op();
        test_present_mask();
        test_count_wrap();
        test_random_traffic();
        drain_results();

        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
